### hdl/ptts_pkg.sv
`default_nettype none

package ptts_pkg;

   // field widths
   localparam int COORD_W = 10;
   localparam int SIZE_W  = 10;
   localparam int WIN_W   = 8;
   localparam int POS_W   = 12;

   // behaviour constants
   localparam int MOVE_PERIOD    = 4;
   localparam int RUN_LIMIT      = 30;
   localparam int FRACTION_STEPS = 5;
   localparam int SMALL_SIZE     = 28;

   // derived widths
   localparam int PHASE_W = (MOVE_PERIOD > 1) ? $clog2(MOVE_PERIOD) : 1;
   // the run count may take two whole steps past the limit before it is checked
   localparam int RUN_W   = $clog2(RUN_LIMIT + 3);
   // signed sub-step count, transiently reaching +/- FRACTION_STEPS
   localparam int FRAC_W  = $clog2(FRACTION_STEPS + 1) + 1;
   localparam int LOCK_W  = 2;

   localparam logic [LOCK_W-1:0] LOCK_FULL = LOCK_W'(2);

   // reset values of the servo positions
   localparam logic [POS_W-1:0] PAN_RESET  = POS_W'(2000);
   localparam logic [POS_W-1:0] TILT_RESET = POS_W'(2050);

   // reset values of the control registers
   localparam logic [COORD_W-1:0] AIM_X_RESET        = COORD_W'(325);
   localparam logic [COORD_W-1:0] AIM_Y_RESET        = COORD_W'(268);
   localparam logic [WIN_W-1:0]   LOCK_WINDOW_RESET  = WIN_W'(5);
   localparam logic [WIN_W-1:0]   LOCK_SMALL_RESET   = WIN_W'(6);
   localparam logic [POS_W-1:0]   PAN_MIN_RESET      = POS_W'(1800);
   localparam logic [POS_W-1:0]   PAN_MAX_RESET      = POS_W'(2200);
   localparam logic [POS_W-1:0]   TILT_MIN_RESET     = POS_W'(1950);
   localparam logic [POS_W-1:0]   TILT_MAX_RESET     = POS_W'(2200);

   // one axis' sub-step request for this frame
   typedef struct packed {
      logic move;   // axis outside the window and motion allowed
      logic up;     // direction: 1 adds, 0 subtracts
   } axis_cmd_type;

endpackage

`default_nettype wire

### hdl/pan_tilt_tracking_stepper_top.sv
`default_nettype none

// Pan/tilt tracking stepper.
// req_ channel: one item per camera frame (object x, y and size). rsp_ channel: one item
// back per frame with both servo positions, the per-axis send flags, locked and
// forced_pause. Both channels are valid/ready; an item moves when valid and ready are high
// at a rising edge.
// Path: an item taken on req_ passes through two registers (the input register and the result
// register) on its way to rsp_. Throughput: one item per cycle while rsp_ready stays high.
// The whole per-frame update (window test, lock count, sub-step and clamp per axis, run
// limit, send compare) sits between those two registers and updates the tracking state as
// the item moves into the result register.
// Receiver stall: the result register holds; one more item may wait in the input register,
// after which req_ready drops until rsp_ready returns.
// Reset (synchronous, active high): both channels empty, registers back to their defaults,
// servos at pan 2000 / tilt 2050 with nothing outstanding to send.
// Control registers via APB at byte address 4*i: aim_x, aim_y, lock_window,
// lock_window_small, pan_min, pan_max, tilt_min, tilt_max. Write only while idle.
module pan_tilt_tracking_stepper_top (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // request channel
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic [ptts_pkg::COORD_W-1:0]     req_object_x,
   input  wire logic [ptts_pkg::COORD_W-1:0]     req_object_y,
   input  wire logic [ptts_pkg::SIZE_W-1:0]      req_object_size,
   // result channel
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic      [ptts_pkg::POS_W-1:0]       rsp_pan_position,
   output logic      [ptts_pkg::POS_W-1:0]       rsp_tilt_position,
   output logic                                  rsp_pan_send,
   output logic                                  rsp_tilt_send,
   output logic                                  rsp_locked,
   output logic                                  rsp_forced_pause,
   // control registers
   input  wire logic                             psel,
   input  wire logic                             penable,
   input  wire logic                             pwrite,
   input  wire logic [4:0]                       paddr,
   input  wire logic [31:0]                      pwdata,
   output logic      [31:0]                      prdata,
   output logic                                  pready
);

   typedef enum logic [2:0] {
      REG_AIM_X      = 3'd0,
      REG_AIM_Y      = 3'd1,
      REG_LOCK_WIN   = 3'd2,
      REG_LOCK_SMALL = 3'd3,
      REG_PAN_MIN    = 3'd4,
      REG_PAN_MAX    = 3'd5,
      REG_TILT_MIN   = 3'd6,
      REG_TILT_MAX   = 3'd7
   } reg_index_type;

   localparam int CW = ptts_pkg::COORD_W;
   localparam int PW = ptts_pkg::POS_W;
   localparam int WW = ptts_pkg::WIN_W;

   // ---------------- control registers ----------------
   logic [CW-1:0] aim_x_ff;
   logic [CW-1:0] aim_y_ff;
   logic [WW-1:0] lock_win_ff;
   logic [WW-1:0] lock_small_ff;
   logic [PW-1:0] pan_min_ff;
   logic [PW-1:0] pan_max_ff;
   logic [PW-1:0] tilt_min_ff;
   logic [PW-1:0] tilt_max_ff;

   reg_index_type reg_sel;
   logic          csr_write;

   assign reg_sel   = reg_index_type'(paddr[4:2]);
   assign csr_write = psel && penable && pwrite;
   assign pready    = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         aim_x_ff      <= ptts_pkg::AIM_X_RESET;
         aim_y_ff      <= ptts_pkg::AIM_Y_RESET;
         lock_win_ff   <= ptts_pkg::LOCK_WINDOW_RESET;
         lock_small_ff <= ptts_pkg::LOCK_SMALL_RESET;
         pan_min_ff    <= ptts_pkg::PAN_MIN_RESET;
         pan_max_ff    <= ptts_pkg::PAN_MAX_RESET;
         tilt_min_ff   <= ptts_pkg::TILT_MIN_RESET;
         tilt_max_ff   <= ptts_pkg::TILT_MAX_RESET;
      end else if (csr_write) begin
         unique case (reg_sel)
            REG_AIM_X:      aim_x_ff      <= pwdata[CW-1:0];
            REG_AIM_Y:      aim_y_ff      <= pwdata[CW-1:0];
            REG_LOCK_WIN:   lock_win_ff   <= pwdata[WW-1:0];
            REG_LOCK_SMALL: lock_small_ff <= pwdata[WW-1:0];
            REG_PAN_MIN:    pan_min_ff    <= pwdata[PW-1:0];
            REG_PAN_MAX:    pan_max_ff    <= pwdata[PW-1:0];
            REG_TILT_MIN:   tilt_min_ff   <= pwdata[PW-1:0];
            REG_TILT_MAX:   tilt_max_ff   <= pwdata[PW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_AIM_X:      prdata = 32'(aim_x_ff);
         REG_AIM_Y:      prdata = 32'(aim_y_ff);
         REG_LOCK_WIN:   prdata = 32'(lock_win_ff);
         REG_LOCK_SMALL: prdata = 32'(lock_small_ff);
         REG_PAN_MIN:    prdata = 32'(pan_min_ff);
         REG_PAN_MAX:    prdata = 32'(pan_max_ff);
         REG_TILT_MIN:   prdata = 32'(tilt_min_ff);
         REG_TILT_MAX:   prdata = 32'(tilt_max_ff);
         default:        prdata = '0;
      endcase
   end

   // ---------------- input register ----------------
   logic                             s1_valid_ff;
   logic [CW-1:0]                    s1_x_ff;
   logic [CW-1:0]                    s1_y_ff;
   logic [ptts_pkg::SIZE_W-1:0]      s1_size_ff;
   logic                             s1_adv;   // item moves into the result register
   logic                             req_take;

   assign s1_adv    = s1_valid_ff && (!rsp_valid || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_adv;
   assign req_take  = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_take) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_x_ff    <= req_object_x;
         s1_y_ff    <= req_object_y;
         s1_size_ff <= req_object_size;
      end
   end

   // ---------------- tracking state ----------------
   logic [PW-1:0]                          pan_now_ff,  pan_now_in;
   logic [PW-1:0]                          tilt_now_ff, tilt_now_in;
   logic [PW-1:0]                          pan_sent_ff, pan_sent_in;
   logic [PW-1:0]                          tilt_sent_ff, tilt_sent_in;
   logic signed [ptts_pkg::FRAC_W-1:0]     pan_fifths_ff, pan_fifths_in;
   logic signed [ptts_pkg::FRAC_W-1:0]     tilt_fifths_ff, tilt_fifths_in;
   logic [ptts_pkg::LOCK_W-1:0]            lock_frames_ff, lock_frames_in;
   logic [ptts_pkg::PHASE_W-1:0]           move_phase_ff, move_phase_in;
   logic [ptts_pkg::RUN_W-1:0]             step_run_ff, step_run_in;

   // ---------------- per-frame update ----------------
   logic signed [CW:0]          err_x;
   logic signed [CW:0]          err_y;
   logic signed [CW:0]          neg_x;
   logic signed [CW:0]          neg_y;
   logic [CW-1:0]               mag_x;
   logic [CW-1:0]               mag_y;
   logic [WW-1:0]               win;
   logic                        in_x;
   logic                        in_y;
   logic                        allow;
   logic [ptts_pkg::LOCK_W-1:0] lock_inc;
   logic                        hold;
   logic                        pause;
   logic                        pan_diff;
   logic                        tilt_diff;
   logic [ptts_pkg::RUN_W-1:0]  run_sum;
   ptts_pkg::axis_cmd_type      pan_cmd;
   ptts_pkg::axis_cmd_type      tilt_cmd;
   logic [PW-1:0]               pan_next;
   logic [PW-1:0]               tilt_next;
   logic signed [ptts_pkg::FRAC_W-1:0] pan_f_next;
   logic signed [ptts_pkg::FRAC_W-1:0] tilt_f_next;
   logic                        pan_stepped;
   logic                        tilt_stepped;

   // phase advances first; motion only on the wrap
   assign move_phase_in = (move_phase_ff == ptts_pkg::PHASE_W'(ptts_pkg::MOVE_PERIOD - 1))
                          ? '0 : (move_phase_ff + 1'b1);
   assign allow = (move_phase_in == '0);

   // pan error is aim - object, tilt error is object - aim
   assign err_x = $signed({1'b0, aim_x_ff}) - $signed({1'b0, s1_x_ff});
   assign err_y = $signed({1'b0, s1_y_ff}) - $signed({1'b0, aim_y_ff});
   assign neg_x = -err_x;
   assign neg_y = -err_y;
   assign mag_x = err_x[CW] ? neg_x[CW-1:0] : err_x[CW-1:0];
   assign mag_y = err_y[CW] ? neg_y[CW-1:0] : err_y[CW-1:0];

   assign win  = (s1_size_ff < ptts_pkg::SIZE_W'(ptts_pkg::SMALL_SIZE)) ? lock_small_ff
                                                                       : lock_win_ff;
   assign in_x = (mag_x <= CW'(win));
   assign in_y = (mag_y <= CW'(win));

   assign lock_inc = (lock_frames_ff == ptts_pkg::LOCK_FULL) ? ptts_pkg::LOCK_FULL
                                                             : (lock_frames_ff + 1'b1);
   assign hold = in_x && in_y && (lock_inc == ptts_pkg::LOCK_FULL);

   // positive pan error steps pan down, positive tilt error steps tilt up
   assign pan_cmd.move  = allow && !in_x && !hold;
   assign pan_cmd.up    = !(err_x > 0);
   assign tilt_cmd.move = allow && !in_y && !hold;
   assign tilt_cmd.up   = (err_y > 0);

   ptts_axis u_pan (
      .cmd         (pan_cmd),
      .fifths      (pan_fifths_ff),
      .pos         (pan_now_ff),
      .pos_lo      (pan_min_ff),
      .pos_hi      (pan_max_ff),
      .fifths_next (pan_f_next),
      .pos_next    (pan_next),
      .stepped     (pan_stepped)
   );

   ptts_axis u_tilt (
      .cmd         (tilt_cmd),
      .fifths      (tilt_fifths_ff),
      .pos         (tilt_now_ff),
      .pos_lo      (tilt_min_ff),
      .pos_hi      (tilt_max_ff),
      .fifths_next (tilt_f_next),
      .pos_next    (tilt_next),
      .stepped     (tilt_stepped)
   );

   assign run_sum   = step_run_ff + ptts_pkg::RUN_W'(pan_stepped)
                                  + ptts_pkg::RUN_W'(tilt_stepped);
   assign pause     = !hold && (run_sum > ptts_pkg::RUN_W'(ptts_pkg::RUN_LIMIT));
   assign pan_diff  = (pan_next != pan_sent_ff);
   assign tilt_diff = (tilt_next != tilt_sent_ff);

   always_comb begin
      pan_now_in     = pan_next;
      tilt_now_in    = tilt_next;
      pan_fifths_in  = pan_f_next;
      tilt_fifths_in = tilt_f_next;
      pan_sent_in    = pan_sent_ff;
      tilt_sent_in   = tilt_sent_ff;
      if (hold || pause) begin
         // locked, or run limit hit: clear the run, count as locked, send nothing
         lock_frames_in = ptts_pkg::LOCK_FULL;
         step_run_in    = '0;
      end else begin
         lock_frames_in = (in_x && in_y) ? lock_inc : '0;
         step_run_in    = (pan_diff || tilt_diff) ? run_sum : '0;
         if (pan_diff) begin
            pan_sent_in = pan_next;
         end
         if (tilt_diff) begin
            tilt_sent_in = tilt_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pan_now_ff     <= ptts_pkg::PAN_RESET;
         tilt_now_ff    <= ptts_pkg::TILT_RESET;
         pan_sent_ff    <= ptts_pkg::PAN_RESET;
         tilt_sent_ff   <= ptts_pkg::TILT_RESET;
         pan_fifths_ff  <= '0;
         tilt_fifths_ff <= '0;
         lock_frames_ff <= '0;
         move_phase_ff  <= '0;
         step_run_ff    <= '0;
      end else if (s1_adv) begin
         pan_now_ff     <= pan_now_in;
         tilt_now_ff    <= tilt_now_in;
         pan_sent_ff    <= pan_sent_in;
         tilt_sent_ff   <= tilt_sent_in;
         pan_fifths_ff  <= pan_fifths_in;
         tilt_fifths_ff <= tilt_fifths_in;
         lock_frames_ff <= lock_frames_in;
         move_phase_ff  <= move_phase_in;
         step_run_ff    <= step_run_in;
      end
   end

   // ---------------- result register ----------------
   logic          rsp_valid_ff;
   logic [PW-1:0] rsp_pan_ff;
   logic [PW-1:0] rsp_tilt_ff;
   logic          rsp_pan_send_ff;
   logic          rsp_tilt_send_ff;
   logic          rsp_locked_ff;
   logic          rsp_pause_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_pan_ff       <= pan_next;
         rsp_tilt_ff      <= tilt_next;
         rsp_pan_send_ff  <= !hold && !pause && pan_diff;
         rsp_tilt_send_ff <= !hold && !pause && tilt_diff;
         rsp_locked_ff    <= hold;
         rsp_pause_ff     <= pause;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pan_position  = rsp_pan_ff;
   assign rsp_tilt_position = rsp_tilt_ff;
   assign rsp_pan_send      = rsp_pan_send_ff;
   assign rsp_tilt_send     = rsp_tilt_send_ff;
   assign rsp_locked        = rsp_locked_ff;
   assign rsp_forced_pause  = rsp_pause_ff;

`ifndef SYNTHESIS
   // the run count never rests above the limit
   assert property (@(posedge clock) disable iff (reset)
      step_run_ff <= ptts_pkg::RUN_W'(ptts_pkg::RUN_LIMIT))
      else $error("step run count above limit");

   // a locked or paused frame sends nothing, and is never both
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_locked || rsp_forced_pause) |->
         !rsp_pan_send && !rsp_tilt_send && !(rsp_locked && rsp_forced_pause))
      else $error("send flag on a locked or paused frame");

   // a forced pause leaves the lock count full
   assert property (@(posedge clock) disable iff (reset)
      s1_adv && pause |=> lock_frames_ff == ptts_pkg::LOCK_FULL)
      else $error("lock count not full after forced pause");

   // after a send the sent copy matches the shown pan position
   assert property (@(posedge clock) disable iff (reset)
      s1_adv && !hold && !pause && pan_diff |=> pan_sent_ff == rsp_pan_position)
      else $error("pan sent copy out of step with result");
`endif

endmodule

`default_nettype wire

### hdl/ptts_axis.sv
`default_nettype none

// One axis: add a signed sub-step, and on a whole step move and clamp the position.
module ptts_axis (
   input  wire ptts_pkg::axis_cmd_type                    cmd,
   input  wire logic signed [ptts_pkg::FRAC_W-1:0]        fifths,
   input  wire logic        [ptts_pkg::POS_W-1:0]         pos,
   input  wire logic        [ptts_pkg::POS_W-1:0]         pos_lo,
   input  wire logic        [ptts_pkg::POS_W-1:0]         pos_hi,
   output logic signed      [ptts_pkg::FRAC_W-1:0]        fifths_next,
   output logic             [ptts_pkg::POS_W-1:0]         pos_next,
   output logic                                           stepped
);

   localparam int EXT_W = ptts_pkg::POS_W + 2;
   localparam logic signed [ptts_pkg::FRAC_W-1:0] FRAC_ONE  = ptts_pkg::FRAC_W'(1);
   localparam logic signed [ptts_pkg::FRAC_W-1:0] FRAC_FULL =
      ptts_pkg::FRAC_W'(ptts_pkg::FRACTION_STEPS);

   logic signed [ptts_pkg::FRAC_W-1:0] f_sum;
   logic                               full_up;
   logic                               full_dn;
   logic signed [EXT_W-1:0]            pos_ext;
   logic signed [EXT_W-1:0]            lo_ext;
   logic signed [EXT_W-1:0]            hi_ext;
   logic signed [EXT_W-1:0]            moved;
   logic        [ptts_pkg::POS_W-1:0]  clamped;

   assign f_sum   = cmd.up ? (fifths + FRAC_ONE) : (fifths - FRAC_ONE);
   assign full_up = cmd.move && (f_sum == FRAC_FULL);
   assign full_dn = cmd.move && (f_sum == -FRAC_FULL);
   assign stepped = full_up || full_dn;

   assign pos_ext = $signed({2'b00, pos});
   assign lo_ext  = $signed({2'b00, pos_lo});
   assign hi_ext  = $signed({2'b00, pos_hi});
   assign moved   = full_up ? (pos_ext + EXT_W'(1)) : (pos_ext - EXT_W'(1));

   // low limit is checked first, so it wins when a moved position breaks both crossed limits
   always_comb begin
      if (moved < lo_ext) begin
         clamped = pos_lo;
      end else if (moved > hi_ext) begin
         clamped = pos_hi;
      end else begin
         clamped = moved[ptts_pkg::POS_W-1:0];
      end
   end

   always_comb begin
      if (stepped) begin
         fifths_next = '0;
         pos_next    = clamped;
      end else if (cmd.move) begin
         fifths_next = f_sum;
         pos_next    = pos;
      end else begin
         fifths_next = fifths;
         pos_next    = pos;
      end
   end

endmodule

`default_nettype wire
